// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the shared buffer multi-queue modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SBMQ_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sbmq assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define SBMQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbmq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBMQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbmq assertion failed");

`endif

// ===== hdl/sbmq_pkg.sv =====
// Package for the shared buffer multi-queue unit: controller states, codes and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sbmq_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DEQ
    } state_t;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       enq_commit;
        logic       deq_issue;
        logic       deq_commit;
        logic       respond;
        logic [1:0] status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_deq;
        logic q_valid;
        logic q_nonempty;
        logic store_empty;
    } dp_stat_t;

endpackage

// ===== hdl/sbmq_ctrl.sv =====
// Controller state machine of the shared buffer multi-queue unit.
// Depends on sbmq_pkg and assert_macros.svh; drives the datapath by ctrl_cmd_t.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbmq_ctrl
    import sbmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!stat.req_deq)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                    if (!stat.q_valid || stat.store_empty)
                    begin
                        cmd.status = STAT_OVERFLOW;
                    end
                    else
                    begin
                        cmd.enq_commit = 1'b1;
                    end
                end
                else if (!stat.q_valid || !stat.q_nonempty)
                begin
                    cmd.respond = 1'b1;
                    cmd.status  = STAT_UNDERFLOW;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.deq_issue = 1'b1;
                    state_next    = S_DEQ;
                end
            end
            S_DEQ:
            begin
                cmd.deq_commit = 1'b1;
                cmd.respond    = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SBMQ_ASSERT_NXT(a_deq_completes, cmd.deq_issue, cmd.deq_commit && cmd.respond)
    `SBMQ_ASSERT_IMP(a_capture_when_idle, cmd.capture, !busy && start)

endmodule

// ===== hdl/sbmq_dp.sv =====
// Datapath of the shared buffer multi-queue unit: slot data and link memories,
// queue head and tail memories, free list registers and result registers.
// Depends on sbmq_pkg and assert_macros.svh; commanded by sbmq_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbmq_dp
    import sbmq_pkg::*;
#(
    parameter int NUM_QUEUES = 8,
    parameter int NUM_SLOTS  = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  logic                req_type,
    input  logic [2:0]          queue_id,
    input  logic signed [31:0]  value,
    output dp_stat_t            stat,
    output logic                done,
    output logic signed [31:0]  read_value,
    output logic [1:0]          status,
    output logic                store_full
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = SW + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] SLOT_COUNT = CW'(NUM_SLOTS);
    localparam logic [QW+2:0] QUEUE_COUNT = (QW + 3)'(NUM_QUEUES);

    logic signed [31:0] slot_data_mem [NUM_SLOTS];
    logic [SW-1:0]      slot_link_mem [NUM_SLOTS];
    logic [SW-1:0]      qhead_mem [NUM_QUEUES];
    logic [SW-1:0]      qtail_mem [NUM_QUEUES];

    logic               req_type_reg;
    logic [QW-1:0]      qidx_reg;
    logic               q_valid_reg;
    logic signed [31:0] value_reg;
    logic [SW-1:0]      qhead_rd_reg;
    logic [SW-1:0]      qtail_rd_reg;
    logic [SW-1:0]      link_rd_reg;
    logic [SW-1:0]      link_addr_reg;
    logic signed [31:0] data_rd_reg;

    logic [SW-1:0]         free_head_reg;
    logic [SW-1:0]         free_head_next;
    logic [CW-1:0]         free_count_reg;
    logic [CW-1:0]         free_count_next;
    logic [CW-1:0]         hwm_reg;
    logic [CW-1:0]         hwm_next;
    logic [NUM_QUEUES-1:0] nonempty_reg;
    logic [NUM_QUEUES-1:0] nonempty_next;
    logic                  done_reg;
    logic signed [31:0]    read_value_reg;
    logic [1:0]            status_reg;
    logic                  store_full_reg;

    logic [QW+2:0] qid_wide;
    logic [QW-1:0] qidx_in;
    logic          q_valid_in;
    logic          nonempty_cur;
    logic          last_elem;
    logic [SW-1:0] link_succ;
    logic [SW-1:0] link_val;
    logic [SW-1:0] link_raddr;
    logic          link_ren;
    logic          link_wen;
    logic [SW-1:0] link_waddr;

    assign qid_wide   = (QW + 3)'(queue_id);
    assign qidx_in    = qid_wide[QW-1:0];
    assign q_valid_in = qid_wide < QUEUE_COUNT;

    assign nonempty_cur = nonempty_reg[qidx_reg];
    assign last_elem    = qhead_rd_reg == qtail_rd_reg;

    // Slots at or above the high-water mark have never had their link written,
    // so their link memory word is not used: the link is taken as the next slot in order.
    assign link_succ = (link_addr_reg == LAST_SLOT) ? '0 : link_addr_reg + SW'(1);
    assign link_val  = ({1'b0, link_addr_reg} >= hwm_reg) ? link_succ : link_rd_reg;

    assign link_ren   = cmd.capture || cmd.deq_issue;
    assign link_raddr = cmd.deq_issue ? qhead_rd_reg : free_head_reg;
    assign link_wen   = (cmd.enq_commit && nonempty_cur) || cmd.deq_commit;
    assign link_waddr = cmd.deq_commit ? qhead_rd_reg : qtail_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            qidx_reg     <= qidx_in;
            q_valid_reg  <= q_valid_in;
            value_reg    <= value;
            qhead_rd_reg <= qhead_mem[qidx_in];
            qtail_rd_reg <= qtail_mem[qidx_in];
        end
        if (link_ren)
        begin
            link_rd_reg   <= slot_link_mem[link_raddr];
            link_addr_reg <= link_raddr;
        end
        if (link_wen)
        begin
            slot_link_mem[link_waddr] <= free_head_reg;
        end
        if (cmd.deq_issue)
        begin
            data_rd_reg <= slot_data_mem[qhead_rd_reg];
        end
        if (cmd.enq_commit)
        begin
            slot_data_mem[free_head_reg] <= value_reg;
            qtail_mem[qidx_reg]          <= free_head_reg;
        end
        if (cmd.enq_commit && !nonempty_cur)
        begin
            qhead_mem[qidx_reg] <= free_head_reg;
        end
        else if (cmd.deq_commit && !last_elem)
        begin
            qhead_mem[qidx_reg] <= link_val;
        end
    end

    always_comb
    begin
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        hwm_next        = hwm_reg;
        nonempty_next   = nonempty_reg;
        if (cmd.enq_commit)
        begin
            free_head_next          = link_val;
            free_count_next         = free_count_reg - CW'(1);
            nonempty_next[qidx_reg] = 1'b1;
            if ({1'b0, free_head_reg} >= hwm_reg)
            begin
                hwm_next = hwm_reg + CW'(1);
            end
        end
        else if (cmd.deq_commit)
        begin
            free_head_next = qhead_rd_reg;
            if (free_count_reg != SLOT_COUNT)
            begin
                free_count_next = free_count_reg + CW'(1);
            end
            if (last_elem)
            begin
                nonempty_next[qidx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_count_reg <= SLOT_COUNT;
            hwm_reg        <= '0;
            nonempty_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            hwm_reg        <= hwm_next;
            nonempty_reg   <= nonempty_next;
            done_reg       <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            read_value_reg <= cmd.deq_commit ? data_rd_reg : '0;
            status_reg     <= cmd.status;
            store_full_reg <= free_count_next == '0;
        end
    end

    assign stat.req_deq     = req_type_reg == REQ_DEQ;
    assign stat.q_valid     = q_valid_reg;
    assign stat.q_nonempty  = nonempty_cur;
    assign stat.store_empty = free_count_reg == '0;

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign store_full = store_full_reg;

    `SBMQ_ASSERT(a_count_bound, free_count_reg <= SLOT_COUNT && hwm_reg <= SLOT_COUNT)
    `SBMQ_ASSERT(a_used_below_hwm, (SLOT_COUNT - free_count_reg) <= hwm_reg)
    `SBMQ_ASSERT_IMP(a_enq_has_slot, cmd.enq_commit, free_count_reg != '0 && q_valid_reg)

endmodule

// ===== hdl/shared_buffer_multi_queue_unit.sv =====
// Shared buffer multi-queue unit: NUM_QUEUES FIFO queues in one store of NUM_SLOTS slots.
// An enqueue or a rejected request passes through the IDLE and LOOKUP states, a dequeue
// also through DEQ, set by the registered reads of the queue pointer memory and then the slot link and data memories.
// done pulses in the cycle after the last working state; busy is low again in that cycle.
// Asynchronous active-low reset empties all queues and frees all slots; no clearing pass.
// Depends on sbmq_pkg, sbmq_ctrl and sbmq_dp.
`timescale 1ns / 1ps

module shared_buffer_multi_queue_unit
    import sbmq_pkg::*;
#(
    parameter int NUM_QUEUES = 8,
    parameter int NUM_SLOTS  = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [2:0]         queue_id,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic               store_full
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    sbmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sbmq_dp #(
        .NUM_QUEUES (NUM_QUEUES),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .queue_id   (queue_id),
        .value      (value),
        .stat       (stat),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .store_full (store_full)
    );

endmodule
